FILE: src/card_uid_access_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the card identifier access table
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef CARD_UID_ACCESS_TABLE_MACROS_SVH
`define CARD_UID_ACCESS_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CUAT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CUAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cuat_pkg.sv
// ----------------------------------------------------------------------------
// cuat_pkg
// Types, codes and sizes shared by the access table controller and cells.
// ----------------------------------------------------------------------------
package cuat_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int UID_W       = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TOTAL_W     = 7;

  // Request codes of an input item
  typedef enum logic [1:0] {
    REQ_PRESENT  = 2'd0,
    REQ_ADD      = 2'd1,
    REQ_DELETE   = 2'd2,
    REQ_RESERVED = 2'd3
  } req_t;

  // Outcome codes of a result item
  typedef enum logic [2:0] {
    OUT_ADMIN     = 3'd0,
    OUT_GRANTED   = 3'd1,
    OUT_DENIED    = 3'd2,
    OUT_ADDED     = 3'd3,
    OUT_FULL      = 3'd4,
    OUT_DELETED   = 3'd5,
    OUT_NOT_FOUND = 3'd6
  } outcome_t;

  // Operation carried by a sweep along the cell row
  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  // Broadcast to every cell for the duration of a sweep
  typedef struct packed {
    op_t              op;
    logic [UID_W-1:0] uid;
    logic             uid_ok;
  } cmd_t;

  // Token handed from one cell to the next
  typedef struct packed {
    logic             tok;
    logic             fnd;
    logic [CNT_W-1:0] rem;
  } link_t;

  // Low bits of the entry count as reported in a result item
  function automatic logic [TOTAL_W-1:0] total_bits(logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[TOTAL_W-1:0];
  endfunction

endpackage

FILE: src/cuat_cell.sv
// ----------------------------------------------------------------------------
// cuat_cell
// One table slot: holds an identifier, compares it when the sweep token
// passes, takes the right neighbor's entry to close a gap, and forwards the
// token to the next slot.
// ----------------------------------------------------------------------------
module cuat_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cuat_pkg::cmd_t              cmd,
  input  cuat_pkg::link_t             link_in,
  output cuat_pkg::link_t             link_out,
  input  logic [cuat_pkg::UID_W-1:0]  data_in,
  output logic [cuat_pkg::UID_W-1:0]  data_out
);

  logic [cuat_pkg::UID_W-1:0] data_r, data_nxt;
  cuat_pkg::link_t            link_r, link_nxt;
  logic                       occupied;
  logic                       hit;
  logic                       wr;
  logic                       shift;

  // Decide what this slot does while the token sits here
  always_comb begin
    occupied = (link_in.rem != '0);
    hit      = link_in.tok && occupied && cmd.uid_ok && (cmd.op != cuat_pkg::OP_ADD)
               && (data_r == cmd.uid);
    wr       = link_in.tok && (cmd.op == cuat_pkg::OP_ADD) && !occupied && !link_in.fnd;
    shift    = link_in.tok && (cmd.op == cuat_pkg::OP_DELETE) && (link_in.fnd || hit);
  end

  // Store a new entry or pull the neighbor's entry down
  always_comb begin
    data_nxt = data_r;
    priority if (wr) begin
      data_nxt = cmd.uid;
    end else if (shift) begin
      data_nxt = data_in;
    end
  end

  // Advance the token, counting down the occupied slots still ahead
  always_comb begin
    link_nxt.tok = link_in.tok;
    link_nxt.fnd = link_in.fnd || hit || wr;
    link_nxt.rem = occupied ? (link_in.rem - cuat_pkg::CNT_W'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= '0;
    end else begin
      link_r <= link_nxt;
    end
  end

  assign link_out = link_r;
  assign data_out = data_r;

endmodule

FILE: src/cuat_ctl.sv
// ----------------------------------------------------------------------------
// cuat_ctl
// Sequencer: accepts an item, settles master, full and reserved cases at once, launches
// a sweep along the cell row otherwise, and holds the result item until taken.
// ----------------------------------------------------------------------------
`include "card_uid_access_table_macros.svh"

module cuat_ctl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cuat_pkg::UID_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [cuat_pkg::UID_W-1:0]    in_card_uid,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_outcome,
  output logic                          out_admin_mode,
  output logic [cuat_pkg::TOTAL_W-1:0]  out_entry_total,
  output cuat_pkg::cmd_t                cmd,
  output cuat_pkg::link_t               link_head,
  input  cuat_pkg::link_t               link_tail
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_FIN   = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [cuat_pkg::UID_W-1:0]    master_r, master_nxt;
  logic                          admin_r, admin_nxt;
  logic [cuat_pkg::CNT_W-1:0]    count_r, count_nxt;
  cuat_pkg::cmd_t                cmd_r, cmd_nxt;
  logic                          start_r, start_nxt;
  cuat_pkg::outcome_t            pend_r, pend_nxt;
  logic                          out_valid_r, out_valid_nxt;
  cuat_pkg::outcome_t            out_outcome_r, out_outcome_nxt;
  logic                          out_admin_r, out_admin_nxt;
  logic [cuat_pkg::TOTAL_W-1:0]  out_total_r, out_total_nxt;
  logic                          accept;
  logic                          in_uid_ok;
  logic                          out_free;
  logic                          table_full;
  logic                          count_ok;

  assign accept     = (state_r == ST_IDLE) && in_valid;
  assign in_uid_ok  = (in_card_uid[cuat_pkg::UID_W-1 -: 8] != 8'd0);
  assign out_free   = !out_valid_r || !out_stall;
  assign table_full = (count_r >= cuat_pkg::CNT_W'(cuat_pkg::TABLE_DEPTH));
  assign count_ok   = (count_r <= cuat_pkg::CNT_W'(cuat_pkg::TABLE_DEPTH));

  // Configuration write
  assign master_nxt = cfg_wr_en ? cfg_wr_data : master_r;

  // Sequence one item
  always_comb begin
    state_nxt = state_r;
    admin_nxt = admin_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    start_nxt = 1'b0;
    pend_nxt  = pend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt.uid    = in_card_uid;
          cmd_nxt.uid_ok = in_uid_ok;
          unique case (cuat_pkg::req_t'(in_req_type))
            cuat_pkg::REQ_PRESENT: begin
              if (in_uid_ok && (in_card_uid == master_r)) begin
                admin_nxt = !admin_r;
                pend_nxt  = cuat_pkg::OUT_ADMIN;
                state_nxt = ST_FIN;
              end else begin
                cmd_nxt.op = cuat_pkg::OP_SEARCH;
                start_nxt  = 1'b1;
                state_nxt  = ST_SWEEP;
              end
            end
            cuat_pkg::REQ_ADD: begin
              if (table_full) begin
                pend_nxt  = cuat_pkg::OUT_FULL;
                state_nxt = ST_FIN;
              end else begin
                cmd_nxt.op = cuat_pkg::OP_ADD;
                start_nxt  = 1'b1;
                state_nxt  = ST_SWEEP;
              end
            end
            cuat_pkg::REQ_DELETE: begin
              cmd_nxt.op = cuat_pkg::OP_DELETE;
              start_nxt  = 1'b1;
              state_nxt  = ST_SWEEP;
            end
            cuat_pkg::REQ_RESERVED: begin
              pend_nxt  = cuat_pkg::OUT_DENIED;
              state_nxt = ST_FIN;
            end
            default: begin
              pend_nxt  = cuat_pkg::OUT_DENIED;
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        // Token leaves the last cell: the whole row has been visited
        if (link_tail.tok) begin
          state_nxt = ST_FIN;
          unique case (cmd_r.op)
            cuat_pkg::OP_SEARCH: begin
              pend_nxt = link_tail.fnd ? cuat_pkg::OUT_GRANTED : cuat_pkg::OUT_DENIED;
            end
            cuat_pkg::OP_ADD: begin
              pend_nxt  = cuat_pkg::OUT_ADDED;
              count_nxt = count_r + cuat_pkg::CNT_W'(1);
            end
            cuat_pkg::OP_DELETE: begin
              if (link_tail.fnd) begin
                pend_nxt  = cuat_pkg::OUT_DELETED;
                count_nxt = count_r - cuat_pkg::CNT_W'(1);
              end else begin
                pend_nxt = cuat_pkg::OUT_NOT_FOUND;
              end
            end
            default: begin
              pend_nxt = cuat_pkg::OUT_DENIED;
            end
          endcase
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Load the result register when it is free, drop the item once taken
  always_comb begin
    out_valid_nxt   = out_valid_r && out_stall;
    out_outcome_nxt = out_outcome_r;
    out_admin_nxt   = out_admin_r;
    out_total_nxt   = out_total_r;
    if ((state_r == ST_FIN) && out_free) begin
      out_valid_nxt   = 1'b1;
      out_outcome_nxt = pend_r;
      out_admin_nxt   = admin_r;
      out_total_nxt   = cuat_pkg::total_bits(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      master_r    <= '0;
      admin_r     <= 1'b0;
      count_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      master_r    <= master_nxt;
      admin_r     <= admin_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    pend_r        <= pend_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_admin_r   <= out_admin_nxt;
    out_total_r   <= out_total_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_outcome     = out_outcome_r;
  assign out_admin_mode  = out_admin_r;
  assign out_entry_total = out_total_r;
  assign cmd             = cmd_r;

  // Feed the head of the cell row
  always_comb begin
    link_head.tok = start_r;
    link_head.fnd = 1'b0;
    link_head.rem = count_r;
  end

  `CUAT_ASSERT_SAME(a_state_onehot, 1'b1, $onehot(state_r), "state register not one-hot")
  `CUAT_ASSERT_SAME(a_count_range, 1'b1, count_ok, "entry count beyond table depth")
  `CUAT_ASSERT_SAME(a_tail_in_sweep, link_tail.tok, state_r == ST_SWEEP, "token outside sweep")
  `CUAT_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != ST_IDLE, "accept stayed idle")
  `CUAT_ASSERT_NEXT(a_start_pulse, start_r, !start_r && (state_r == ST_SWEEP), "start not a pulse")

endmodule

FILE: src/card_uid_access_table.sv
// Master, full and reserved requests go straight to the finish state, which loads the
// result register; search, add and delete first walk the token along every slot cell.
// One item at a time: no new item is accepted until the sequencer is idle again, and the
// finish state waits while a held result is stalled. A finished result waits in the
// output register and does not block the next accept. Reset (synchronous, active low)
// clears state, start, valid flag, entry count, admin flag, master register and links.
// ----------------------------------------------------------------------------
// card_uid_access_table
// Authorized card identifier list with admin-mode toggle, built as a row of
// slot cells swept by a token from a central sequencer.
// ----------------------------------------------------------------------------
module card_uid_access_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [31:0]                   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [31:0]                   in_card_uid,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_outcome,
  output logic                          out_admin_mode,
  output logic [6:0]                    out_entry_total
);

  cuat_pkg::cmd_t             cmd;
  cuat_pkg::link_t            link [cuat_pkg::TABLE_DEPTH+1];
  logic [cuat_pkg::UID_W-1:0] cell_data [cuat_pkg::TABLE_DEPTH];

  cuat_ctl u_ctl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_card_uid     (in_card_uid),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_outcome     (out_outcome),
    .out_admin_mode  (out_admin_mode),
    .out_entry_total (out_entry_total),
    .cmd             (cmd),
    .link_head       (link[0]),
    .link_tail       (link[cuat_pkg::TABLE_DEPTH])
  );

  // Row of slots; each pulls from its right neighbor, the last one from itself
  for (genvar g = 0; g < cuat_pkg::TABLE_DEPTH; g++) begin : g_cell
    logic [cuat_pkg::UID_W-1:0] right_data;
    if (g == cuat_pkg::TABLE_DEPTH - 1) begin : g_last
      assign right_data = cell_data[g];
    end else begin : g_mid
      assign right_data = cell_data[g+1];
    end
    cuat_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .link_in  (link[g]),
      .link_out (link[g+1]),
      .data_in  (right_data),
      .data_out (cell_data[g])
    );
  end

endmodule
